FILE: rtl/es_pkg.sv
`timescale 1ns / 1ps
package es_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

FILE: rtl/es_ram.sv
`timescale 1ns / 1ps
module es_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/es_cmp.sv
`timescale 1ns / 1ps
module es_cmp (
  input  es_pkg::value_t held,
  input  es_pkg::value_t probe,
  input  logic           descending,
  output logic           swap
);

  import es_pkg::*;

  logic probe_lt;
  logic held_lt;

  // Equal values never swap.
  assign probe_lt = probe < held;
  assign held_lt  = held < probe;
  assign swap     = descending ? held_lt : probe_lt;

endmodule

FILE: rtl/exchange_sort_engine_core.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// input     in_valid / in_stall       value, last
// output    out_valid / out_stall     sorted_value, final_res, overflowed
// config    cfg_valid / cfg_ready     descending
//
// Collection takes one value per cycle. A run of n stored values is then sorted
// with one compare per cycle through the single compare unit and the
// one-write/one-read element RAM. Each result goes out through a registered RAM
// read, then the output register, and waits while that register is not free. Input stalls from the
// last value of a run until its final result sits in the output register.
// Synchronous active-high reset clears control state; the RAM is not cleared.
module exchange_sort_engine_core #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  es_pkg::value_t value,
  input  logic           last,
  output logic           out_valid,
  input  logic           out_stall,
  output es_pkg::value_t sorted_value,
  output logic           final_res,
  output logic           overflowed,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           descending
);

  import es_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [2:0] {
    S_FILL,
    S_RD_I,
    S_LD,
    S_SCAN,
    S_STORE_I,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t         state;
  logic [CW-1:0]  count;
  logic [CW-1:0]  n;
  logic [CW-1:0]  i;
  logic [CW-1:0]  j;
  logic [CW-1:0]  jd;
  logic [CW-1:0]  k;
  logic           ovf;
  logic           desc;
  value_t         cur;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  value_t         ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  value_t         ram_rdata;

  logic           in_acc;
  logic           out_acc;
  logic           has_room;
  logic           swap;
  logic [CW-1:0]  n_m1;
  logic [CW-1:0]  count_next;
  logic           out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_FILL);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign has_room  = count < CW'(MAX_ELEMENTS);
  assign n_m1      = n - CW'(1);
  assign out_free  = !out_valid || out_acc;
  // Count after this transaction: a dropped value leaves it unchanged.
  assign count_next = has_room ? count + CW'(1) : count;

  es_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Held element i against the element just read from position jd.
  es_cmp u_cmp (
    .held       (cur),
    .probe      (ram_rdata),
    .descending (desc),
    .swap       (swap)
  );

  // RAM port steering per state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = value;
    ram_re    = 1'b0;
    ram_raddr = i[AW-1:0];
    case (state)
      S_FILL: begin
        // Store while there is room; a full store drops the value.
        ram_we = in_acc && has_room;
      end
      S_RD_I: begin
        ram_re = 1'b1;
      end
      S_LD: begin
        ram_re    = 1'b1;
        ram_raddr = j[AW-1:0];
      end
      S_SCAN: begin
        // Put the held value at jd when the pair is out of order, and
        // keep reading ahead.
        ram_we    = swap;
        ram_waddr = jd[AW-1:0];
        ram_wdata = cur;
        ram_re    = 1'b1;
        ram_raddr = j[AW-1:0];
      end
      S_STORE_I: begin
        // Write back the winner for position i, fetch position i+1.
        ram_we    = 1'b1;
        ram_waddr = i[AW-1:0];
        ram_wdata = cur;
        ram_re    = 1'b1;
        ram_raddr = i[AW-1:0] + AW'(1);
      end
      S_EMIT_RD: begin
        ram_re    = out_free;
        ram_raddr = k[AW-1:0];
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      count     <= '0;
      ovf       <= 1'b0;
      desc      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        desc <= descending;
      end
      if (out_acc) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          if (in_acc) begin
            count <= count_next;
            if (!has_room) begin
              ovf <= 1'b1;
            end
            if (last) begin
              n <= count_next;
              i <= '0;
              j <= CW'(1);
              k <= '0;
              // A single element needs no sort pass.
              state <= (count_next > CW'(1)) ? S_RD_I : S_EMIT_RD;
            end
          end
        end
        S_RD_I: begin
          state <= S_LD;
        end
        S_LD: begin
          cur   <= ram_rdata;
          jd    <= j;
          j     <= j + CW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (swap) begin
            cur <= ram_rdata;
          end
          jd <= j;
          j  <= j + CW'(1);
          if (jd == n_m1) begin
            state <= S_STORE_I;
          end
        end
        S_STORE_I: begin
          if (i + CW'(2) == n) begin
            k     <= '0;
            state <= S_EMIT_RD;
          end else begin
            i     <= i + CW'(1);
            j     <= i + CW'(2);
            state <= S_LD;
          end
        end
        S_EMIT_RD: begin
          // Hold until the output register is free.
          if (out_free) begin
            state <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          out_valid    <= 1'b1;
          sorted_value <= ram_rdata;
          final_res    <= (k == n_m1);
          overflowed   <= ovf;
          if (k == n_m1) begin
            // Run done: open the input while the final result waits.
            count <= '0;
            ovf   <= 1'b0;
            state <= S_FILL;
          end else begin
            k     <= k + CW'(1);
            state <= S_EMIT_RD;
          end
        end
        default: begin
          state <= S_FILL;
        end
      endcase
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for exchange_sort_engine_core.
// Runs of signed values go in, and each run closes with a marked value. The bench
// keeps its own copy of the store and sorts each closed run by exchange sort. It
// checks every sorted transaction against that copy, including the final mark and
// the overflow flag. The order register is only written while the engine is idle.
module tb;
  import es_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int MAX_GAP = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;
  localparam int ITEM_TARGET = 440;

  localparam value_t VALUE_MIN = 32'sh8000_0000;
  localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    value_t val;
    logic   fin;
    logic   ovf;
  } sorted_entry_t;

  logic   clk;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  value_t value = '0;
  logic   last = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  value_t sorted_value;
  logic   final_res;
  logic   overflowed;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic   descending = 1'b0;

  // Shadow state: the values of the open run, its drop flag and the sort order.
  value_t        stored_vals[$];
  bit            run_dropped;
  bit            order_desc;
  sorted_entry_t pending_results[$];

  // Drop all idling on both sides while this is set.
  bit busy_mode;

  int cycle_count;
  int mismatches;
  int items_sent;
  int runs_done;
  int overflow_runs;
  int results_seen;
  int cfg_writes;
  int stall_left;

  exchange_sort_engine_core #(
    .MAX_ELEMENTS(STORE_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sorted_value(sorted_value),
    .final_res   (final_res),
    .overflowed  (overflowed),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .descending  (descending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up on a hung engine.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("tb failed");
      $finish;
    end
  end

  // Store one accepted value in the shadow copy. On the marked value, sort the
  // stored set by exchange sort and queue one expected transaction per element.
  task automatic predict_item(input value_t v, input logic l);
    value_t work[$];
    value_t tmp;
    bit     swap;
    int     i;
    int     j;
    int     k;
    if (stored_vals.size() < STORE_DEPTH) begin
      stored_vals.push_back(v);
    end else begin
      // Store full: drop the value, flag the whole run.
      run_dropped = 1'b1;
    end
    if (l) begin
      work = stored_vals;
      for (i = 0; i + 1 < work.size(); i++) begin
        for (j = i + 1; j < work.size(); j++) begin
          // Swap only strictly out-of-order pairs; equal values stay put.
          swap = order_desc ? (work[i] < work[j]) : (work[j] < work[i]);
          if (swap) begin
            tmp = work[i];
            work[i] = work[j];
            work[j] = tmp;
          end
        end
      end
      for (k = 0; k < work.size(); k++) begin
        pending_results.push_back('{work[k], k == work.size() - 1, run_dropped});
      end
      runs_done++;
      if (run_dropped) overflow_runs++;
      stored_vals.delete();
      run_dropped = 1'b0;
    end
  endtask

  // Present one value after a random gap. Hold the payload until the engine
  // takes it. Leave valid high, so that a back-to-back value follows without a
  // bubble.
  task automatic send_item(input value_t v, input logic l);
    int gap;
    gap = busy_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value <= v;
    last <= l;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_item(v, l);
  endtask

  function automatic value_t draw_value();
    case ($urandom_range(0, 9))
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      // Small values around zero make duplicates and sign changes common.
      2, 3: return value_t'($urandom_range(0, 16)) - 8;
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic send_run(input int len);
    int k;
    for (k = 0; k < len; k++) send_item(draw_value(), k == len - 1);
  endtask

  // Hold the input off until every owed transaction is back. Then let the engine
  // settle before anyone touches the order register.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_order(input bit d);
    cfg_valid <= 1'b1;
    descending <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    order_desc = d;
    cfg_writes++;
  endtask

  // Output side: check each accepted transaction against the oldest expectation
  // and draw a random stall after it. While nothing is offered, start the odd
  // stall too, so that the first result of a run also meets a held stall.
  always @(posedge clk) begin
    sorted_entry_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected result: value %0d final %b overflow %b",
                     sorted_value, final_res, overflowed);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (sorted_value !== want.val || final_res !== want.fin ||
              overflowed !== want.ovf) begin
            if (mismatches < REPORT_MAX)
              $display("result %0d: expected value %0d final %b overflow %b, got %0d %b %b",
                       results_seen, want.val, want.fin, want.ovf,
                       sorted_value, final_res, overflowed);
            mismatches++;
          end
        end
        stall_left = busy_mode ? 0 : $urandom_range(0, MAX_GAP);
      end else if (!out_valid && stall_left == 0 && !busy_mode &&
                   $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, MAX_GAP);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // One-value runs at both ends of the range and at zero, all with the default order.
  task automatic test_single_values();
    send_item(VALUE_MIN, 1'b1);
    send_item(VALUE_MAX, 1'b1);
    send_item('0, 1'b1);
    wait_idle();
  endtask

  // Run with both extremes twice, zero, plus and minus one, and alternating bit
  // patterns in the given order.
  task automatic test_extremes(input bit d);
    value_t pattern[9];
    int     k;
    pattern = '{VALUE_MAX, VALUE_MIN, 32'sd0, -32'sd1, 32'sd1, VALUE_MAX, VALUE_MIN,
                32'sh5555_5555, 32'shAAAA_AAAA};
    set_order(d);
    for (k = 0; k < 9; k++) send_item(pattern[k], k == 8);
    wait_idle();
  endtask

  // Store exactly full in ascending order. Then go one over in descending order,
  // so that the marked value itself is dropped and still closes the run.
  task automatic test_store_limits();
    set_order(1'b0);
    send_run(STORE_DEPTH);
    wait_idle();
    set_order(1'b1);
    send_run(STORE_DEPTH + 1);
    wait_idle();
  endtask

  // Phases of random runs. Each phase has its own order setting, and every third
  // one runs with no idling at all. Most runs are short, some are long up to the
  // store depth, and a few overflow it.
  task automatic test_random_runs();
    int phase;
    int len;
    int r;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      set_order(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
      busy_mode = (phase % 3 == 2);
      repeat ($urandom_range(2, 6)) begin
        r = $urandom_range(0, 19);
        if (r < 15) len = $urandom_range(1, 10);
        else if (r < 19) len = $urandom_range(11, STORE_DEPTH);
        else len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
        send_run(len);
      end
      wait_idle();
      busy_mode = 1'b0;
      phase++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_single_values();
    test_extremes(1'b0);
    test_extremes(1'b1);
    test_store_limits();
    test_random_runs();

    $display("sent %0d values in %0d runs, %0d of them overflowed; checked %0d results",
             items_sent, runs_done, overflow_runs, results_seen);
    $display("order register written %0d times, both orders, with and without idling",
             cfg_writes);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: exchange_sort_engine_core.f
rtl/es_pkg.sv
rtl/es_ram.sv
rtl/es_cmp.sv
rtl/exchange_sort_engine_core.sv
verif/tb.sv
